// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Full property, clocked on clk, disabled while arst_n is low
`define BPHD_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Same-cycle implication, clocked on clk, disabled while arst_n is low
`define BPHD_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/bphd_pkg.sv =====
// ----------------------------------------------------------------------------
// bphd_pkg
// Types and constants shared by the button press / hold detector.
// ----------------------------------------------------------------------------
package bphd_pkg;

	// Width of every per-button field on the ports
	localparam int FIELD_W   = 4;
	// Width of the debounce and hold counters
	localparam int CNT_W     = 8;
	localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;
	localparam logic [CNT_W-1:0] CNT_ONE = 8'h01;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_COUNT   = 2'd2;

	// Configuration reset values
	localparam logic             RST_ACTIVE_LEVEL = 1'b1;
	localparam logic [CNT_W-1:0] RST_PRESS_COUNT  = 8'd5;
	localparam logic [CNT_W-1:0] RST_HOLD_COUNT   = 8'd50;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_PRESSED = 2'd1,
		PH_HOLDING = 2'd2
	} bphd_phase_t;

	typedef struct packed {
		logic             active_level;
		logic [CNT_W-1:0] press_count;
		logic [CNT_W-1:0] hold_count;
	} bphd_cfg_t;

	// Per-button events of one tick
	typedef struct packed {
		logic short_press;
		logic hold_start;
		logic hold_release;
		logic holding;
	} bphd_evt_t;

endpackage

// ===== rtl/button_press_hold_detector.sv =====
// ----------------------------------------------------------------------------
// button_press_hold_detector
// Debounces a row of buttons, detects short presses and long holds, and
// toggles the LED of each short-pressed button.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------
//  in      | input     | in_valid / in_stall   | button_levels, led_states
//  out     | output    | out_valid / out_stall | led_states_next, masks
//  cfg     | input     | cfg_wr_en             | cfg_index, cfg_data
//
//  One transaction accepted per cycle while in_stall is low; each result passes
//  through the input register, then the result register, before it is presented.
//  Button state is read and written in the input stage, so consecutive ticks
//  see each other's updates with no gap.
//  Reset clears button state, valid flags and loads configuration defaults.
//  A held result stalls the input stage only once both stages are full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module button_press_hold_detector #(
	parameter int NUM_BUTTONS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [bphd_pkg::FIELD_W-1:0]      button_levels,
	input  logic [bphd_pkg::FIELD_W-1:0]      led_states,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [bphd_pkg::FIELD_W-1:0]      led_states_next,
	output logic [bphd_pkg::FIELD_W-1:0]      short_press_mask,
	output logic [bphd_pkg::FIELD_W-1:0]      hold_start_mask,
	output logic [bphd_pkg::FIELD_W-1:0]      hold_release_mask,
	output logic [bphd_pkg::FIELD_W-1:0]      holding_mask,
	input  logic                              cfg_wr_en,
	input  logic [bphd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bphd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import bphd_pkg::*;

	// Buttons above the field width never see an active pin change on the ports
	localparam int LANES = (NUM_BUTTONS < FIELD_W) ? NUM_BUTTONS : FIELD_W;

	bphd_cfg_t cfg_q;

	logic               v_s1;
	logic [FIELD_W-1:0] levels_s1;
	logic [FIELD_W-1:0] leds_s1;
	logic               adv_s1;
	logic               take_in;

	logic [FIELD_W-1:0] short_m;
	logic [FIELD_W-1:0] start_m;
	logic [FIELD_W-1:0] release_m;
	logic [FIELD_W-1:0] hold_m;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_level <= RST_ACTIVE_LEVEL;
			cfg_q.press_count  <= RST_PRESS_COUNT;
			cfg_q.hold_count   <= RST_HOLD_COUNT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ACTIVE_LEVEL: cfg_q.active_level <= cfg_data[0];
				REG_PRESS_COUNT:  cfg_q.press_count  <= cfg_data[CNT_W-1:0];
				REG_HOLD_COUNT:   cfg_q.hold_count   <= cfg_data[CNT_W-1:0];
				default:          ;
			endcase
		end
	end

	// Handshake: stage 1 moves on when the result register is free or draining
	assign adv_s1   = v_s1 && (!out_valid || !out_stall);
	assign in_stall = v_s1 && !adv_s1;
	assign take_in  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take_in) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			levels_s1 <= button_levels;
			leds_s1   <= led_states;
		end
	end

	// One lane per scanned button
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		bphd_evt_t evt;

		bphd_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.upd    (adv_s1),
			.level  (levels_s1[i]),
			.cfg    (cfg_q),
			.evt    (evt)
		);

		assign short_m[i]   = evt.short_press;
		assign start_m[i]   = evt.hold_start;
		assign release_m[i] = evt.hold_release;
		assign hold_m[i]    = evt.holding;
	end

	// Tie off field bits with no button behind them
	for (genvar i = LANES; i < FIELD_W; i++) begin : g_unused
		assign short_m[i]   = 1'b0;
		assign start_m[i]   = 1'b0;
		assign release_m[i] = 1'b0;
		assign hold_m[i]    = 1'b0;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || !out_stall) begin
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			led_states_next   <= leds_s1 ^ short_m;
			short_press_mask  <= short_m;
			hold_start_mask   <= start_m;
			hold_release_mask <= release_m;
			holding_mask      <= hold_m;
		end
	end

	`BPHD_ASSERT_IMPL(a_stall_only_full, in_stall, (v_s1 && out_valid && out_stall),
		"input stalled while a stage was free")
	`BPHD_ASSERT(a_s1_keeps_item, (v_s1 && !adv_s1) |=> v_s1,
		"input stage dropped a waiting transaction")
	`BPHD_ASSERT_IMPL(a_events_exclusive, out_valid,
		((short_press_mask & hold_release_mask) == '0) && ((hold_start_mask & ~holding_mask) == '0),
		"conflicting events in one result")

endmodule

// ===== rtl/bphd_lane.sv =====
// ----------------------------------------------------------------------------
// bphd_lane
// One button: debounce counter, hold counter and phase, with the events that
// a single scan tick produces.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bphd_lane (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 upd,
	input  logic                 level,
	input  bphd_pkg::bphd_cfg_t  cfg,
	output bphd_pkg::bphd_evt_t  evt
);
	import bphd_pkg::*;

	logic [CNT_W-1:0] db_q;
	logic [CNT_W-1:0] held_q;
	bphd_phase_t      phase_q;

	logic [CNT_W-1:0] db_d;
	logic [CNT_W-1:0] held_d;
	bphd_phase_t      phase_d;
	logic             hit;

	// Advance the counters for this tick; clear both when the level is inactive
	always_comb begin
		hit    = (level == cfg.active_level);
		db_d   = '0;
		held_d = '0;
		if (hit) begin
			db_d = (db_q == CNT_MAX) ? CNT_MAX : db_q + CNT_ONE;
			if ((db_q < cfg.press_count) && (db_d == cfg.press_count)) begin
				held_d = CNT_ONE;
			end else if ((db_q >= cfg.press_count) && (held_q != CNT_MAX)) begin
				held_d = held_q + CNT_ONE;
			end else begin
				held_d = held_q;
			end
		end
	end

	// Step the phase and raise events
	always_comb begin
		phase_d          = phase_q;
		evt.short_press  = 1'b0;
		evt.hold_start   = 1'b0;
		evt.hold_release = 1'b0;
		if ((held_d == CNT_ONE) && (phase_q == PH_IDLE)) begin
			phase_d = PH_PRESSED;
		end else if ((held_d >= cfg.hold_count) && (phase_q == PH_PRESSED)) begin
			phase_d        = PH_HOLDING;
			evt.hold_start = 1'b1;
		end else if (held_d == '0) begin
			case (phase_q)
				PH_HOLDING: evt.hold_release = 1'b1;
				PH_PRESSED: evt.short_press  = 1'b1;
				default:    ;
			endcase
			phase_d = PH_IDLE;
		end
		evt.holding = (phase_d == PH_HOLDING);
	end

	// Commit state when the transaction leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			db_q    <= '0;
			held_q  <= '0;
			phase_q <= PH_IDLE;
		end else if (upd) begin
			db_q    <= db_d;
			held_q  <= held_d;
			phase_q <= phase_d;
		end
	end

	`BPHD_ASSERT(a_start_enters_hold, (upd && evt.hold_start) |=> (phase_q == PH_HOLDING),
		"hold start did not leave the lane in holding")
	`BPHD_ASSERT(a_release_clears, (upd && !hit) |=> ((db_q == '0) && (held_q == '0) && (phase_q == PH_IDLE)),
		"release did not clear the lane")
	`BPHD_ASSERT_IMPL(a_idle_no_count, (phase_q == PH_IDLE) && (held_q > CNT_ONE), 1'b0,
		"idle lane with a running hold count")

endmodule
